// ===== rtl/core/pbe_pkg.sv =====
// Package for the pixel buffer engine: field widths, command codes and control structs.
package pbe_pkg;

    localparam int CMD_W          = 3;
    localparam int PIX_W          = 10;
    localparam int COLOR_W        = 24;
    localparam int SHIFT_W        = 16;
    localparam int CFG_W          = 11;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 3;
    localparam int DIVIDEND_W     = 16;
    localparam int DIVISOR_W      = 11;
    localparam int DIV_CNT_W      = 4;
    localparam int DIV_K_W        = 3;
    localparam int DEF_MAX_PIXELS = 1024;

    localparam logic [CFG_W-1:0]   ACTIVE_RESET = 11'd1024;
    localparam logic [DIV_K_W-1:0] DIV_K_LAST   = DIV_K_W'(2 * NUM_CH - 1);

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_SET    = 3'd0;
    localparam cmd_t CMD_GET    = 3'd1;
    localparam cmd_t CMD_FILL   = 3'd2;
    localparam cmd_t CMD_GRAD   = 3'd3;
    localparam cmd_t CMD_MIRROR = 3'd4;
    localparam cmd_t CMD_ROTATE = 3'd5;
    localparam cmd_t CMD_UPDATE = 3'd6;

    typedef enum logic [2:0] {
        WSRC_COLOR,
        WSRC_GRAD,
        WSRC_RD_A,
        WSRC_RD_B,
        WSRC_SCRATCH
    } wsrc_t;

    typedef struct packed {
        logic  accept;
        logic  clr_en;
        logic  init_range;
        logic  div_start;
        logic  rot_init;
        logic  rd_en;
        logic  wr_en;
        logic  wr_hi;
        wsrc_t wsrc;
        logic  copy_wr;
        logic  adv;
        logic  sa_adv;
        logic  resp_load;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic pix_ok;
        logic range_ok;
        logic diff_zero;
        logic at_last;
        logic mir_done;
        logic div_done;
        logic div_k_last;
        logic off_zero;
        logic clr_last;
    } dp_stat_t;

endpackage

// ===== rtl/core/pbe_ifs.sv =====
// Stream and configuration interfaces of the pixel buffer engine.
interface pbe_item_if;
    import pbe_pkg::*;
    logic                      valid;
    logic                      ready;
    cmd_t                      cmd;
    logic [PIX_W-1:0]          range_start;
    logic [PIX_W-1:0]          range_end;
    logic [COLOR_W-1:0]        color_a;
    logic [COLOR_W-1:0]        color_b;
    logic signed [SHIFT_W-1:0] shift_amount;
    modport source (output valid, cmd, range_start, range_end, color_a, color_b,
                    shift_amount, input ready);
    modport sink (input valid, cmd, range_start, range_end, color_a, color_b,
                  shift_amount, output ready);
endinterface

interface pbe_result_if;
    import pbe_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] read_color;
    logic               show_request;
    logic               status;
    modport source (output valid, read_color, show_request, status, input ready);
    modport sink (input valid, read_color, show_request, status, output ready);
endinterface

interface pbe_cfg_if;
    import pbe_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/pbe_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module pbe_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pbe_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [pbe_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [pbe_pkg::DIVIDEND_W-1:0] quotient,
    output logic [pbe_pkg::DIVISOR_W-1:0]  remainder
);
    import pbe_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, den_reg}) : trial[DIVISOR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/pbe_datapath.sv =====
// Datapath: pixel store, scratch store, pointers, gradient stepping and result register.
module pbe_datapath #(
    parameter int MAX_PIXELS = pbe_pkg::DEF_MAX_PIXELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pbe_pkg::dp_ctrl_t                 ctl,
    output pbe_pkg::dp_stat_t                 stat,
    input  logic                              cfg_valid,
    input  logic [pbe_pkg::CFG_W-1:0]         cfg_data,
    input  pbe_pkg::cmd_t                     cmd,
    input  logic [pbe_pkg::PIX_W-1:0]         range_start,
    input  logic [pbe_pkg::PIX_W-1:0]         range_end,
    input  logic [pbe_pkg::COLOR_W-1:0]       color_a,
    input  logic [pbe_pkg::COLOR_W-1:0]       color_b,
    input  logic signed [pbe_pkg::SHIFT_W-1:0] shift_amount,
    output logic [pbe_pkg::COLOR_W-1:0]       read_color,
    output logic                              show_request,
    output logic                              status
);
    import pbe_pkg::*;

    localparam int AW        = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int MAX_CLAMP = (MAX_PIXELS > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1 : MAX_PIXELS;
    localparam logic [CFG_W-1:0] MAX_BOUND = CFG_W'(MAX_CLAMP);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(MAX_PIXELS - 1);

    logic [COLOR_W-1:0] store_mem [MAX_PIXELS];
    logic [COLOR_W-1:0] scratch_mem [MAX_PIXELS];

    logic [CFG_W-1:0]   active_reg;
    cmd_t               cmd_reg;
    logic [PIX_W-1:0]   first_reg;
    logic [PIX_W-1:0]   last_reg;
    logic [COLOR_W-1:0] color_a_reg;
    logic [COLOR_W-1:0] color_b_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [PIX_W-1:0]   p_reg;
    logic [PIX_W-1:0]   q_reg;
    logic [PIX_W-1:0]   sa_reg;
    logic [AW-1:0]      clr_reg;
    logic [COLOR_W-1:0] rd_a_reg;
    logic [COLOR_W-1:0] rd_b_reg;
    logic [COLOR_W-1:0] scr_rd_reg;
    logic               changed_reg;
    logic [DIV_K_W-1:0] div_k_reg;
    logic [CFG_W-1:0]   rot_rem_reg;
    logic [COLOR_W-1:0] read_color_reg;
    logic               show_reg;
    logic               status_reg;

    logic [CH_W-1:0]  qa_reg [NUM_CH];
    logic [PIX_W-1:0] ra_reg [NUM_CH];
    logic [CH_W-1:0]  qb_reg [NUM_CH];
    logic [PIX_W-1:0] rb_reg [NUM_CH];
    logic [CH_W-1:0]  gaq_reg [NUM_CH];
    logic [PIX_W-1:0] gar_reg [NUM_CH];
    logic [CH_W-1:0]  gbq_reg [NUM_CH];
    logic [PIX_W-1:0] gbr_reg [NUM_CH];
    logic [CH_W-1:0]  gaq_next [NUM_CH];
    logic [PIX_W-1:0] gar_next [NUM_CH];
    logic [CH_W-1:0]  gbq_next [NUM_CH];
    logic [PIX_W-1:0] gbr_next [NUM_CH];
    logic [CH_W-1:0]  grad_ch [NUM_CH];

    logic [CFG_W-1:0]      bound;
    logic                  pix_ok;
    logic                  range_ok;
    logic [PIX_W-1:0]      diff;
    logic [CFG_W-1:0]      count;
    logic [1:0]            div_ch;
    logic [CH_W-1:0]       div_byte;
    logic [DIVIDEND_W-1:0] shift_mag;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVISOR_W-1:0]  div_rem;
    logic [CFG_W-1:0]      rot_start;
    logic [COLOR_W-1:0]    grad_color;
    logic [COLOR_W-1:0]    wdata;
    logic [COLOR_W-1:0]    wold;
    logic [PIX_W-1:0]      waddr;
    logic                  bad;

    assign bound    = (active_reg < MAX_BOUND) ? active_reg : MAX_BOUND;
    assign pix_ok   = CFG_W'(first_reg) < bound;
    assign range_ok = (first_reg <= last_reg) && (CFG_W'(last_reg) < bound);
    assign diff     = last_reg - first_reg;
    assign count    = CFG_W'(diff) + 1'b1;

    assign stat.cmd        = cmd_reg;
    assign stat.pix_ok     = pix_ok;
    assign stat.range_ok   = range_ok;
    assign stat.diff_zero  = diff == '0;
    assign stat.at_last    = p_reg == last_reg;
    assign stat.mir_done   = (q_reg - p_reg) <= PIX_W'(2);
    assign stat.div_done   = div_done;
    assign stat.div_k_last = div_k_reg == DIV_K_LAST;
    assign stat.off_zero   = rot_rem_reg == '0;
    assign stat.clr_last   = clr_reg == CLR_LAST;

    assign div_ch    = (div_k_reg < DIV_K_W'(NUM_CH)) ? div_k_reg[1:0]
                                                     : 2'(div_k_reg - DIV_K_W'(NUM_CH));
    assign div_byte  = (div_k_reg < DIV_K_W'(NUM_CH)) ? color_a_reg[CH_W*div_ch +: CH_W]
                                                     : color_b_reg[CH_W*div_ch +: CH_W];
    assign shift_mag = shift_reg[SHIFT_W-1] ? (~shift_reg + 1'b1) : shift_reg;

    always_comb
    begin
        if (cmd_reg == CMD_ROTATE)
        begin
            div_dividend = shift_mag;
            div_divisor  = count;
        end
        else
        begin
            div_dividend = DIVIDEND_W'(div_byte);
            div_divisor  = DIVISOR_W'(diff);
        end
    end

    pbe_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign rot_start = (rot_rem_reg == '0) ? '0
                     : (shift_reg[SHIFT_W-1] ? rot_rem_reg : count - rot_rem_reg);

    always_comb
    begin
        logic [PIX_W:0] t;
        for (int c = 0; c < NUM_CH; c++)
        begin
            grad_ch[c] = gaq_reg[c] + gbq_reg[c];
            if (gar_reg[c] < ra_reg[c])
            begin
                t           = {1'b0, gar_reg[c]} + {1'b0, diff} - {1'b0, ra_reg[c]};
                gar_next[c] = t[PIX_W-1:0];
                gaq_next[c] = gaq_reg[c] - qa_reg[c] - 1'b1;
            end
            else
            begin
                gar_next[c] = gar_reg[c] - ra_reg[c];
                gaq_next[c] = gaq_reg[c] - qa_reg[c];
            end
            t = {1'b0, gbr_reg[c]} + {1'b0, rb_reg[c]};
            if (t >= {1'b0, diff})
            begin
                t           = t - {1'b0, diff};
                gbq_next[c] = gbq_reg[c] + qb_reg[c] + 1'b1;
            end
            else
            begin
                gbq_next[c] = gbq_reg[c] + qb_reg[c];
            end
            gbr_next[c] = t[PIX_W-1:0];
        end
    end

    assign grad_color = {grad_ch[2], grad_ch[1], grad_ch[0]};

    always_comb
    begin
        case (ctl.wsrc)
            WSRC_GRAD:    wdata = grad_color;
            WSRC_RD_A:    wdata = rd_a_reg;
            WSRC_RD_B:    wdata = rd_b_reg;
            WSRC_SCRATCH: wdata = scr_rd_reg;
            default:      wdata = color_a_reg;
        endcase
    end

    assign waddr = ctl.wr_hi ? q_reg : p_reg;
    assign wold  = ctl.wr_hi ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        case (cmd_reg) inside
            CMD_SET, CMD_GET:                          bad = !pix_ok;
            CMD_FILL, CMD_GRAD, CMD_MIRROR, CMD_ROTATE: bad = !range_ok;
            default:                                   bad = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr_en)
            store_mem[clr_reg] <= '0;
        else if (ctl.wr_en)
            store_mem[AW'(waddr)] <= wdata;
        if (ctl.rd_en)
        begin
            rd_a_reg <= store_mem[AW'(p_reg)];
            rd_b_reg <= store_mem[AW'(q_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.copy_wr)
            scratch_mem[AW'(p_reg)] <= rd_a_reg;
        if (ctl.rd_en)
            scr_rd_reg <= scratch_mem[AW'(sa_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= ACTIVE_RESET;
            changed_reg <= 1'b0;
            clr_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
                active_reg <= cfg_data;
            if (ctl.clr_en)
                clr_reg <= clr_reg + 1'b1;
            if (ctl.wr_en && (wdata != wold))
                changed_reg <= 1'b1;
            else if (ctl.resp_load && (cmd_reg == CMD_UPDATE))
                changed_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg     <= cmd;
            first_reg   <= range_start;
            last_reg    <= range_end;
            color_a_reg <= color_a;
            color_b_reg <= color_b;
            shift_reg   <= shift_amount;
        end

        if (ctl.init_range)
        begin
            p_reg     <= first_reg;
            q_reg     <= last_reg;
            div_k_reg <= '0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                gaq_reg[c] <= color_a_reg[CH_W*c +: CH_W];
                gar_reg[c] <= '0;
                gbq_reg[c] <= '0;
                gbr_reg[c] <= '0;
            end
        end
        else if (ctl.adv)
        begin
            p_reg <= p_reg + 1'b1;
            q_reg <= q_reg - 1'b1;
            if (cmd_reg == CMD_GRAD)
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    gaq_reg[c] <= gaq_next[c];
                    gar_reg[c] <= gar_next[c];
                    gbq_reg[c] <= gbq_next[c];
                    gbr_reg[c] <= gbr_next[c];
                end
            end
        end

        if (div_done)
        begin
            if (cmd_reg == CMD_ROTATE)
                rot_rem_reg <= div_rem;
            else
            begin
                if (div_k_reg < DIV_K_W'(NUM_CH))
                begin
                    qa_reg[div_ch] <= div_quo[CH_W-1:0];
                    ra_reg[div_ch] <= div_rem[PIX_W-1:0];
                end
                else
                begin
                    qb_reg[div_ch] <= div_quo[CH_W-1:0];
                    rb_reg[div_ch] <= div_rem[PIX_W-1:0];
                end
                div_k_reg <= div_k_reg + 1'b1;
            end
        end

        if (ctl.rot_init)
            sa_reg <= first_reg + rot_start[PIX_W-1:0];
        else if (ctl.sa_adv)
            sa_reg <= (sa_reg == last_reg) ? first_reg : sa_reg + 1'b1;

        if (ctl.resp_load)
        begin
            read_color_reg <= ((cmd_reg == CMD_GET) && pix_ok) ? rd_a_reg : '0;
            show_reg       <= (cmd_reg == CMD_UPDATE) && changed_reg;
            status_reg     <= bad;
        end
    end

    assign read_color   = read_color_reg;
    assign show_request = show_reg;
    assign status       = status_reg;

endmodule

// ===== rtl/core/pbe_controller.sv =====
// Controller state machine: sequences clear pass, divisions, reads and writes per item.
module pbe_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              res_valid,
    input  logic              res_ready,
    input  pbe_pkg::dp_stat_t stat,
    output pbe_pkg::dp_ctrl_t ctl
);
    import pbe_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_DECODE   = 12'b000000000100,
        S_DIV_GO   = 12'b000000001000,
        S_DIV_WAIT = 12'b000000010000,
        S_ROT_SET  = 12'b000000100000,
        S_CP_RD    = 12'b000001000000,
        S_CP_WR    = 12'b000010000000,
        S_RD       = 12'b000100000000,
        S_WR       = 12'b001000000000,
        S_WR2      = 12'b010000000000,
        S_RESP     = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    always_comb
    begin
        ctl        = '0;
        ctl.wsrc   = WSRC_COLOR;
        item_ready = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_en = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.init_range = 1'b1;
                unique case (stat.cmd) inside
                    CMD_SET, CMD_GET:
                        state_next = stat.pix_ok ? S_RD : S_RESP;
                    CMD_FILL:
                        state_next = stat.range_ok ? S_RD : S_RESP;
                    CMD_GRAD:
                        state_next = !stat.range_ok ? S_RESP
                                   : (stat.diff_zero ? S_RD : S_DIV_GO);
                    CMD_MIRROR:
                        state_next = (!stat.range_ok || stat.diff_zero) ? S_RESP : S_RD;
                    CMD_ROTATE:
                        state_next = stat.range_ok ? S_DIV_GO : S_RESP;
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_DIV_GO:
            begin
                ctl.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.cmd == CMD_ROTATE)
                        state_next = S_ROT_SET;
                    else if (stat.div_k_last)
                        state_next = S_RD;
                    else
                        state_next = S_DIV_GO;
                end
            end
            S_ROT_SET:
            begin
                if (stat.off_zero)
                    state_next = S_RESP;
                else
                begin
                    ctl.rot_init = 1'b1;
                    state_next   = S_CP_RD;
                end
            end
            S_CP_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                ctl.copy_wr = 1'b1;
                if (stat.at_last)
                begin
                    ctl.init_range = 1'b1;
                    state_next     = S_RD;
                end
                else
                begin
                    ctl.adv    = 1'b1;
                    state_next = S_CP_RD;
                end
            end
            S_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = (stat.cmd == CMD_GET) ? S_RESP : S_WR;
            end
            S_WR:
            begin
                ctl.wr_en = 1'b1;
                if (stat.cmd == CMD_SET)
                    state_next = S_RESP;
                else if (stat.cmd == CMD_MIRROR)
                begin
                    ctl.wsrc   = WSRC_RD_B;
                    state_next = S_WR2;
                end
                else
                begin
                    if (stat.cmd == CMD_ROTATE)
                    begin
                        ctl.wsrc   = WSRC_SCRATCH;
                        ctl.sa_adv = 1'b1;
                    end
                    else if ((stat.cmd == CMD_GRAD) && !stat.diff_zero)
                        ctl.wsrc = WSRC_GRAD;
                    if (stat.at_last)
                        state_next = S_RESP;
                    else
                    begin
                        ctl.adv    = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_WR2:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_hi  = 1'b1;
                ctl.wsrc   = WSRC_RD_A;
                ctl.adv    = 1'b1;
                state_next = stat.mir_done ? S_RESP : S_RD;
            end
            S_RESP:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    ctl.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctl.resp_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ===== rtl/core/led_pixel_buffer_engine_top.sv =====
// Top level of the LED pixel buffer engine.
//  channel  direction  payload                                           handshake
//  item     in         cmd, range_start, range_end, color_a/b, shift     valid/ready
//  result   out        read_color, show_request, status                  valid/ready
//  cfg      in         data (active_pixels)                              valid/ready
// After reset a clearing pass writes black to all MAX_PIXELS entries, one per cycle.
// Gradient runs 6 divisions and rotate 1 before the pixel pass; rotate then copies its range
// into the scratch store first. Mirror reads both ends of a pair and writes them swapped.
// Each pixel is read and then written in separate cycles.
// One item at a time; the next is taken while the result register waits to be read.
module led_pixel_buffer_engine_top #(
    parameter int MAX_PIXELS = pbe_pkg::DEF_MAX_PIXELS
) (
    input  logic          clk,
    input  logic          rst_n,
    pbe_item_if.sink      item,
    pbe_result_if.source  result,
    pbe_cfg_if.sink       cfg
);
    import pbe_pkg::*;

    dp_ctrl_t ctl;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    pbe_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    pbe_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .cmd          (item.cmd),
        .range_start  (item.range_start),
        .range_end    (item.range_end),
        .color_a      (item.color_a),
        .color_b      (item.color_b),
        .shift_amount (item.shift_amount),
        .read_color   (result.read_color),
        .show_request (result.show_request),
        .status       (result.status)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.resp_load |-> (!result.valid || result.ready))
        else $error("result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_en && !ctl.wr_hi) |-> $past(ctl.rd_en))
        else $error("pixel write without preceding read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item accepted while busy");
`endif

endmodule

// ===== tb/sv/pbe_checker.sv =====
// Checker for the pixel buffer engine: watches the channels, predicts each result and compares.
`timescale 1ns / 1ps
module pbe_checker (
    input  logic          clk,
    input  logic          rst_n,
    pbe_item_if.sink      mon_item,
    pbe_result_if.sink    mon_result,
    pbe_cfg_if.sink       mon_cfg,
    output int            fail_count,
    output int            pending,
    output int            result_count
);
    import pbe_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               show_request;
        logic               status;
    } outcome_t;

    logic [COLOR_W-1:0] strip [DEF_MAX_PIXELS];
    logic [COLOR_W-1:0] snap  [DEF_MAX_PIXELS];
    logic               dirty;
    logic [CFG_W-1:0]   strip_len;
    outcome_t           awaited [$];

    function automatic void put_pixel(int idx, logic [COLOR_W-1:0] c);
        if (strip[idx] != c)
        begin
            strip[idx] = c;
            dirty = 1'b1;
        end
    endfunction

    function automatic logic [7:0] blend(int a, int b, int i, int j, int d);
        return 8'((a * i) / d + (b * j) / d);
    endfunction

    function automatic outcome_t apply_command(cmd_t op, int f, int l,
            logic [COLOR_W-1:0] ca, logic [COLOR_W-1:0] cb, logic signed [SHIFT_W-1:0] sh);
        outcome_t o;
        int bound;
        bit ok;
        int d;
        int n;
        int off;
        int j;
        int src;
        logic [7:0] r, g, b;
        o = '0;
        bound = (strip_len < DEF_MAX_PIXELS) ? int'(strip_len) : DEF_MAX_PIXELS;
        ok = (f <= l) && (l < bound);
        case (op)
            CMD_SET:
                if (f < bound) put_pixel(f, ca); else o.status = 1'b1;
            CMD_GET:
                if (f < bound) o.read_color = strip[f]; else o.status = 1'b1;
            CMD_FILL:
                if (!ok) o.status = 1'b1;
                else for (int p = f; p <= l; p++) put_pixel(p, ca);
            CMD_GRAD:
                if (!ok) o.status = 1'b1;
                else if (l == f) put_pixel(f, ca);
                else
                begin
                    d = l - f;
                    for (int p = f; p <= l; p++)
                    begin
                        j = p - f;
                        r = blend(ca[23:16], cb[23:16], d - j, j, d);
                        g = blend(ca[15:8], cb[15:8], d - j, j, d);
                        b = blend(ca[7:0], cb[7:0], d - j, j, d);
                        put_pixel(p, {r, g, b});
                    end
                end
            CMD_MIRROR:
                if (!ok) o.status = 1'b1;
                else
                begin
                    for (int p = f; p <= l; p++) snap[p] = strip[l - (p - f)];
                    for (int p = f; p <= l; p++) put_pixel(p, snap[p]);
                end
            CMD_ROTATE:
                if (!ok) o.status = 1'b1;
                else
                begin
                    n = l - f + 1;
                    off = int'(sh) % n;
                    if (off < 0) off += n;
                    for (int p = f; p <= l; p++)
                    begin
                        j = p - f;
                        src = (j >= off) ? j - off : j + n - off;
                        snap[p] = strip[f + src];
                    end
                    for (int p = f; p <= l; p++) put_pixel(p, snap[p]);
                end
            CMD_UPDATE:
                if (dirty)
                begin
                    o.show_request = 1'b1;
                    dirty = 1'b0;
                end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            foreach (strip[k]) strip[k] = '0;
            dirty = 1'b0;
            strip_len = ACTIVE_RESET;
            awaited.delete();
            fail_count = 0;
            result_count = 0;
            pending = 0;
        end
        else
        begin
            if (mon_cfg.valid && mon_cfg.ready)
                strip_len = mon_cfg.data;
            if (mon_item.valid && mon_item.ready)
                awaited.push_back(apply_command(mon_item.cmd, mon_item.range_start,
                    mon_item.range_end, mon_item.color_a, mon_item.color_b,
                    mon_item.shift_amount));
            if (mon_result.valid && mon_result.ready)
            begin
                got = '{mon_result.read_color, mon_result.show_request, mon_result.status};
                result_count++;
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h, none expected", got);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch #%0d exp %h/%b/%b got %h/%b/%b",
                                result_count, want.read_color, want.show_request,
                                want.status, got.read_color, got.show_request, got.status);
                    end
                end
            end
            pending = awaited.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the pixel buffer engine: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
    import pbe_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   result_count;
    int   burst_left;
    int   cmd_seen [8];

    pbe_item_if   item ();
    pbe_result_if result ();
    pbe_cfg_if    cfg ();

    led_pixel_buffer_engine_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item.sink),
        .result(result.source),
        .cfg   (cfg.sink)
    );

    pbe_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .mon_item    (item.sink),
        .mon_result  (result.sink),
        .mon_cfg     (cfg.sink),
        .fail_count  (fail_count),
        .pending     (pending),
        .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            case (result_count % 97 < 40 ? 0 : $urandom_range(0, 3))
                0:       result.ready <= 1'b1;
                1:       result.ready <= 1'b0;
                default: result.ready <= $urandom_range(0, 1);
            endcase
    end

    task automatic send_command(cmd_t op, int f, int l, logic [COLOR_W-1:0] ca,
            logic [COLOR_W-1:0] cb, logic signed [SHIFT_W-1:0] sh);
        if (burst_left == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        item.valid        <= 1'b1;
        item.cmd          <= op;
        item.range_start  <= PIX_W'(f);
        item.range_end    <= PIX_W'(l);
        item.color_a      <= ca;
        item.color_b      <= cb;
        item.shift_amount <= sh;
        cmd_seen[op]++;
        do @(posedge clk); while (!item.ready);
    endtask

    task automatic drain_results();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic set_strip_length(logic [CFG_W-1:0] n);
        drain_results();
        cfg.valid <= 1'b1;
        cfg.data  <= n;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_command(int len);
        int   f;
        int   l;
        int   pick;
        cmd_t op;
        f = $urandom_range(0, len - 1);
        l = f + $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0) l = f + $urandom_range(0, 300);
        if (l >= len) l = len - 1;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            f = $urandom_range(0, 1023);
            l = $urandom_range(0, 1023);
        end
        op = cmd_t'($urandom_range(0, 7));
        send_command(op, f, l, COLOR_W'($urandom_range(0, 24'hFFFFFF)),
            COLOR_W'($urandom_range(0, 24'hFFFFFF)), SHIFT_W'($urandom_range(0, 16'hFFFF)));
    endtask

    initial
    begin
        int lens [4];
        rst_n        = 1'b0;
        item.valid   = 1'b0;
        item.cmd     = CMD_SET;
        item.range_start  = '0;
        item.range_end    = '0;
        item.color_a      = '0;
        item.color_b      = '0;
        item.shift_amount = '0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        burst_left   = 0;
        foreach (cmd_seen[k]) cmd_seen[k] = 0;
        lens = '{1024, 1, 37, 2047};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_GET, 1023, 0, '0, '0, '0);
        send_command(CMD_SET, 0, 0, 24'hFFFFFF, '0, '0);
        send_command(CMD_SET, 1023, 0, 24'h123456, '0, '0);
        send_command(CMD_GET, 1023, 0, '0, '0, '0);
        send_command(CMD_UPDATE, 5, 2, '0, '0, '0);
        send_command(CMD_UPDATE, 0, 0, '0, '0, '0);
        send_command(CMD_FILL, 10, 19, 24'hA5A5A5, '0, '0);
        send_command(CMD_FILL, 20, 10, 24'h111111, '0, '0);
        send_command(CMD_GRAD, 0, 9, 24'hFF00FF, 24'h00FF01, '0);
        send_command(CMD_GRAD, 30, 30, 24'h5A5A5A, 24'hFFFFFF, '0);
        send_command(CMD_GRAD, 0, 1023, 24'hFFFFFF, 24'hFFFFFF, '0);
        send_command(CMD_MIRROR, 0, 20, '0, '0, '0);
        send_command(CMD_MIRROR, 7, 7, '0, '0, '0);
        send_command(CMD_ROTATE, 0, 20, '0, '0, 16'sd3);
        send_command(CMD_ROTATE, 0, 20, '0, '0, 16'sh8000);
        send_command(CMD_ROTATE, 3, 9, '0, '0, 16'sd32767);
        send_command(CMD_ROTATE, 0, 1, '0, '0, -16'sd1);
        send_command(cmd_t'(7), 1, 2, 24'hFFFFFF, 24'hFFFFFF, 16'sd1);
        send_command(CMD_UPDATE, 0, 0, '0, '0, '0);
        send_command(CMD_UPDATE, 0, 0, '0, '0, '0);
        for (int k = 0; k < 4; k++)
            send_command(CMD_GET, k, 0, '0, '0, '0);
        drain_results();

        set_strip_length('0);
        send_command(CMD_GET, 0, 0, '0, '0, '0);
        send_command(CMD_FILL, 0, 0, 24'h1, '0, '0);
        foreach (lens[k])
        begin
            set_strip_length(CFG_W'(lens[k]));
            for (int n = 0; n < 140; n++)
                random_command(lens[k] > 1024 ? 1024 : lens[k]);
        end
        drain_results();

        $display("covered %0d results: set %0d get %0d fill %0d gradient %0d mirror %0d",
            result_count, cmd_seen[CMD_SET], cmd_seen[CMD_GET], cmd_seen[CMD_FILL],
            cmd_seen[CMD_GRAD], cmd_seen[CMD_MIRROR]);
        $display("rotate %0d update %0d unused %0d; strip lengths 0, 1, 37, 1024, 2047",
            cmd_seen[CMD_ROTATE], cmd_seen[CMD_UPDATE], cmd_seen[7]);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pbe_pkg.sv
rtl/core/pbe_ifs.sv
rtl/core/pbe_divider.sv
rtl/core/pbe_datapath.sv
rtl/core/pbe_controller.sv
rtl/core/led_pixel_buffer_engine_top.sv
tb/sv/pbe_checker.sv
tb/sv/tb_top.sv
